>>> hdl/mcm_pkg.sv
package mcm_pkg;

  // result field widths
  localparam int COST_W  = 40;
  localparam int SPLIT_W = 4;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = ((COST_W + SPLIT_W + STAT_W + 7) / 8) * 8;
  localparam int PAD_W   = OUT_W - COST_W - SPLIT_W - STAT_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;

  // controller -> datapath strobes
  typedef struct packed {
    logic dims_we;    // store incoming dimension
    logic cost_we;    // write cost table entry
    logic cost_zero;  // entry written is zero (diagonal)
    logic ld_pa;      // latch p[i-1]
    logic ld_ab;      // latch p[i-1]*p[j]
    logic ld_init;    // best <= sentinel, split <= 0
    logic ld_mul;     // latch product and saturated table sum
    logic do_cmp;     // compare candidate against best
    logic ld_out;     // load result register
    logic out_zero;   // result carries zero cost and split
  } mcm_cmd_t;

endpackage

>>> hdl/matrix_chain_order_dp_top.sv
// Matrix chain order solver. Dimension words p0, p1, ... pn stream in on the
// input channel, one per cycle, with tlast on pn. Up to MAX_MATRICES+1
// dimensions are kept; further ones are dropped and reported as status 2.
// After the last word the block fills the interval cost table bottom-up and
// returns one result word: the minimum scalar multiplication count (saturated
// at 2^40-1), the outermost split k (earliest best on ties, low 4 bits) and a
// status (0 ok, 1 fewer than two dimensions, 2 dimensions dropped). A chain
// of n matrices is solved by one datapath that tries one split at a time; a
// tried split passes through read, multiply and compare states, and each
// interval adds states for the reads, the outer dimension product and the
// table write. Input is not taken during the fill. A finished result sits
// in an output register, so the next chain may start loading while it
// waits to be taken.
module matrix_chain_order_dp_top
  import mcm_pkg::*;
#(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DIM_BITS+7)/8)*8-1:0]       in_tdata,   // dimension
  input  logic                                in_tlast,   // last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_W-1:0]                    out_tdata   // min_cost, first_split, status
);

  localparam int IW  = $clog2(MAX_MATRICES);
  localparam int DAW = $clog2(MAX_MATRICES + 1);

  mcm_cmd_t          cmd;
  logic [STAT_W-1:0] status;
  logic [IW-1:0]     kk;
  logic [DAW-1:0]    dims_waddr, dims_raddr;
  logic [2*IW-1:0]   cost_waddr, cost_raddr_a, cost_raddr_b;
  logic              out_busy;
  logic [COST_W-1:0]  out_cost;
  logic [SPLIT_W-1:0] out_split;
  logic [STAT_W-1:0]  out_status;

  // sequencer: dimension loading, interval/split loops, result handoff
  mcm_ctrl #(.MAX_MATRICES(MAX_MATRICES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .out_busy     (out_busy),
    .cmd          (cmd),
    .status       (status),
    .kk           (kk),
    .dims_waddr   (dims_waddr),
    .dims_raddr   (dims_raddr),
    .cost_waddr   (cost_waddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b)
  );

  // storage, cost arithmetic, result register
  mcm_dp #(.MAX_MATRICES(MAX_MATRICES), .DIM_BITS(DIM_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .kk           (kk),
    .dims_waddr   (dims_waddr),
    .dims_raddr   (dims_raddr),
    .cost_waddr   (cost_waddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b),
    .in_dim       (in_tdata[DIM_BITS-1:0]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_busy     (out_busy),
    .out_cost     (out_cost),
    .out_split    (out_split),
    .out_status   (out_status)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_status, out_split, out_cost};

  // a pending result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> !(out_tvalid && !out_tready))
    else $error("result overwritten while pending");

  // the table is not written while words are being loaded
  a_no_fill_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.cost_we && !cmd.do_cmp)
    else $error("table activity while idle");

  // an empty chain reports zero cost and split
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == ST_EMPTY) |-> (out_cost == '0) && (out_split == '0))
    else $error("empty chain with nonzero result");

  // a result load completes the chain and hands control back to loading
  a_ld_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> in_tready && out_tvalid)
    else $error("controller not idle after result");

endmodule

>>> hdl/mcm_ram.sv
module mcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mcm_ctrl.sv
module mcm_ctrl
  import mcm_pkg::*;
#(
  parameter int MAX_MATRICES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_last,
  output logic                                in_ready,
  input  logic                                out_busy,
  output mcm_cmd_t                            cmd,
  output logic [STAT_W-1:0]                   status,
  output logic [$clog2(MAX_MATRICES)-1:0]     kk,
  output logic [$clog2(MAX_MATRICES+1)-1:0]   dims_waddr,
  output logic [$clog2(MAX_MATRICES+1)-1:0]   dims_raddr,
  output logic [2*$clog2(MAX_MATRICES)-1:0]   cost_waddr,
  output logic [2*$clog2(MAX_MATRICES)-1:0]   cost_raddr_a,
  output logic [2*$clog2(MAX_MATRICES)-1:0]   cost_raddr_b
);

  localparam int IW  = $clog2(MAX_MATRICES);
  localparam int DAW = $clog2(MAX_MATRICES + 1);
  localparam int CW  = $clog2(MAX_MATRICES + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIAG = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_MULA = 4'd4;
  localparam logic [3:0] S_RDK  = 4'd5;
  localparam logic [3:0] S_MULK = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              zero_r, zero_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IW-1:0]     nm1_r, nm1_nxt;
  logic [IW-1:0]     r_r, r_nxt;
  logic [IW-1:0]     c_r, c_nxt;
  logic [IW-1:0]     kk_r, kk_nxt;
  logic [CW-1:0]     cnt_after;
  logic              ovf_after;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    zero_nxt   = zero_r;
    status_nxt = status_r;
    nm1_nxt    = nm1_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    kk_nxt     = kk_r;
    cnt_after  = cnt_r;
    ovf_after  = ovf_r;
    cmd        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_MATRICES + 1)) begin
            cmd.dims_we = 1'b1;
            cnt_after   = cnt_r + CW'(1);
          end else begin
            ovf_after = 1'b1;
          end
          if (in_last) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            if (cnt_after < CW'(2)) begin
              status_nxt = ST_EMPTY;
              zero_nxt   = 1'b1;
              state_nxt  = S_OUT;
            end else begin
              status_nxt = ovf_after ? ST_DROP : ST_OK;
              zero_nxt   = 1'b0;
              nm1_nxt    = IW'(cnt_after - CW'(2));
              r_nxt      = IW'(cnt_after - CW'(2));
              state_nxt  = S_DIAG;
            end
          end else begin
            cnt_nxt = cnt_after;
            ovf_nxt = ovf_after;
          end
        end
      end
      S_DIAG: begin
        cmd.cost_we   = 1'b1;
        cmd.cost_zero = 1'b1;
        if (r_r == nm1_r) begin
          // bottom row holds only its diagonal
          if (r_r == '0) begin
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            r_nxt = r_r - IW'(1);
          end
        end else begin
          c_nxt     = r_r + IW'(1);
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        cmd.ld_pa = 1'b1;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.ld_ab   = 1'b1;
        cmd.ld_init = 1'b1;
        kk_nxt      = r_r + IW'(1);
        state_nxt   = S_RDK;
      end
      S_RDK: state_nxt = S_MULK;
      S_MULK: begin
        cmd.ld_mul = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.do_cmp = 1'b1;
        if (kk_r == c_r) begin
          state_nxt = S_WR;
        end else begin
          kk_nxt    = kk_r + IW'(1);
          state_nxt = S_RDK;
        end
      end
      S_WR: begin
        cmd.cost_we = 1'b1;
        if (c_r == nm1_r) begin
          if (r_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            r_nxt     = r_r - IW'(1);
            state_nxt = S_DIAG;
          end
        end else begin
          c_nxt     = c_r + IW'(1);
          state_nxt = S_RDA;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.ld_out   = 1'b1;
          cmd.out_zero = zero_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r   <= zero_nxt;
    status_r <= status_nxt;
    nm1_r    <= nm1_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    kk_r     <= kk_nxt;
  end

  always_comb begin
    if (state_r == S_RDA) begin
      dims_raddr = DAW'(r_r);
    end else if (state_r == S_RDB) begin
      dims_raddr = DAW'(c_r) + DAW'(1);
    end else begin
      dims_raddr = DAW'(kk_r);
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign status       = status_r;
  assign kk           = kk_r;
  assign dims_waddr   = DAW'(cnt_r);
  assign cost_waddr   = (state_r == S_DIAG) ? {r_r, r_r} : {r_r, c_r};
  assign cost_raddr_a = {r_r, kk_r - IW'(1)};
  assign cost_raddr_b = {kk_r, c_r};

endmodule

>>> hdl/mcm_dp.sv
module mcm_dp
  import mcm_pkg::*;
#(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcm_cmd_t                            cmd,
  input  logic [STAT_W-1:0]                   status,
  input  logic [$clog2(MAX_MATRICES)-1:0]     kk,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]   dims_waddr,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]   dims_raddr,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]   cost_waddr,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]   cost_raddr_a,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]   cost_raddr_b,
  input  logic [DIM_BITS-1:0]                 in_dim,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_busy,
  output logic [COST_W-1:0]                   out_cost,
  output logic [SPLIT_W-1:0]                  out_split,
  output logic [STAT_W-1:0]                   out_status
);

  localparam int IW  = $clog2(MAX_MATRICES);
  localparam int PW  = 3 * DIM_BITS;
  localparam int TW  = ((PW > COST_W) ? PW : COST_W) + 1;
  localparam int ROW = 1 << IW;

  logic [DIM_BITS-1:0]   dims_q;
  logic [COST_W-1:0]     cost_a_q, cost_b_q, cost_wdata;
  logic [DIM_BITS-1:0]   pa_r;
  logic [2*DIM_BITS-1:0] ab_r;
  logic [PW-1:0]         prod_w, prod_r;
  logic [COST_W:0]       sum_w;
  logic [COST_W-1:0]     sum_r;
  logic [TW-1:0]         total_w;
  logic [COST_W-1:0]     cand_w;
  logic [COST_W-1:0]     best_r;
  logic [IW-1:0]         where_r;
  logic                  out_valid_r;
  logic [COST_W-1:0]     out_cost_r;
  logic [SPLIT_W-1:0]    out_split_r;
  logic [STAT_W-1:0]     out_status_r;

  mcm_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES + 1)) u_dims (
    .clk   (clk),
    .we    (cmd.dims_we),
    .waddr (dims_waddr),
    .wdata (in_dim),
    .raddr (dims_raddr),
    .rdata (dims_q)
  );

  // two copies of the cost table: both read ports needed per split
  assign cost_wdata = cmd.cost_zero ? '0 : best_r;

  mcm_ram #(.WIDTH(COST_W), .DEPTH(ROW * ROW)) u_cost_a (
    .clk   (clk),
    .we    (cmd.cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (cost_raddr_a),
    .rdata (cost_a_q)
  );

  mcm_ram #(.WIDTH(COST_W), .DEPTH(ROW * ROW)) u_cost_b (
    .clk   (clk),
    .we    (cmd.cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (cost_raddr_b),
    .rdata (cost_b_q)
  );

  assign prod_w  = ab_r * dims_q;
  assign sum_w   = {1'b0, cost_a_q} + {1'b0, cost_b_q};
  assign total_w = TW'(sum_r) + TW'(prod_r);
  assign cand_w  = (total_w > TW'(COST_MAX)) ? COST_MAX : total_w[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.ld_pa) begin
      pa_r <= dims_q;
    end
    if (cmd.ld_ab) begin
      ab_r <= (2*DIM_BITS)'(pa_r) * (2*DIM_BITS)'(dims_q);
    end
    if (cmd.ld_mul) begin
      prod_r <= prod_w;
      sum_r  <= sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];
    end
    if (cmd.ld_init) begin
      best_r  <= COST_MAX;
      where_r <= '0;
    end else if (cmd.do_cmp && (cand_w < best_r)) begin
      best_r  <= cand_w;
      where_r <= kk;
    end
    if (cmd.ld_out) begin
      out_cost_r   <= cmd.out_zero ? '0 : best_r;
      out_split_r  <= cmd.out_zero ? '0 : SPLIT_W'(where_r);
      out_status_r <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_busy   = out_valid_r & ~out_ready;
  assign out_cost   = out_cost_r;
  assign out_split  = out_split_r;
  assign out_status = out_status_r;

endmodule

>>> sim/tb_matrix_chain_order_dp_top.sv
`timescale 1ns / 1ps

module tb_matrix_chain_order_dp_top;
  import mcm_pkg::*;

  localparam int MAX_MATRICES = 16;
  localparam int DIM_BITS     = 10;
  localparam int IN_W         = ((DIM_BITS + 7) / 8) * 8;
  localparam int STORE_DEPTH  = MAX_MATRICES + 1;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
  localparam logic [63:0] COST_LIMIT = 64'(COST_MAX);

  localparam int ITEM_TARGET  = 1550;
  localparam int HOLD_CYCLES  = 4000;  // long receiver hold-off
  localparam int TAIL_CYCLES  = 3000;  // > fill time of a full 16-matrix chain
  localparam int IDLE_LIMIT   = 20000; // no-handshake cycles before giving up

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [SPLIT_W-1:0] split;
    logic [STAT_W-1:0]  status;
  } chain_result_t;

  logic            clk;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;   // dimension
  logic            in_tlast   = 1'b0; // last
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // min_cost, first_split, status

  // predictor state: the chain being loaded
  logic [DIM_BITS-1:0] chain_dims[$];
  bit                  chain_dropped;
  chain_result_t       expected_orders[$];

  int  err_count  = 0;
  int  words_kept = 0;

  // sender burst shaping
  bit  gaps_on    = 1'b1;
  int  burst_left = 0;

  // receiver hold-off request, served in the receiver process
  int  hold_asks  = 0;
  int  hold_done  = 0;

  matrix_chain_order_dp_top #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sat_cost(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > COST_LIMIT) ? COST_LIMIT : s;
  endfunction

  // Interval DP over the stored dimensions; strict < keeps the earliest best split.
  // Partial costs clamp at the 40-bit maximum.
  function automatic chain_result_t best_order();
    logic [63:0]        cost_tab  [MAX_MATRICES][MAX_MATRICES];
    logic [SPLIT_W-1:0] split_tab [MAX_MATRICES][MAX_MATRICES];
    logic [63:0]        best, prod, q;
    logic [SPLIT_W-1:0] best_k;
    chain_result_t      r;
    int                 n;
    r.cost  = '0;
    r.split = '0;
    n = chain_dims.size() - 1;
    if (n >= 1) begin
      for (int i = n; i > 0; i--) begin
        for (int j = i; j <= n; j++) begin
          best   = COST_LIMIT;
          best_k = '0;
          if (i == j) begin
            best = '0;
          end else begin
            for (int k = i; k < j; k++) begin
              prod = 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
              q = sat_cost(sat_cost(cost_tab[i-1][k-1], cost_tab[k][j-1]), prod);
              if (q < best) begin
                best   = q;
                best_k = SPLIT_W'(k);
              end
            end
          end
          cost_tab[i-1][j-1]  = best;
          split_tab[i-1][j-1] = best_k;
        end
      end
      r.cost  = cost_tab[0][n-1][COST_W-1:0];
      r.split = split_tab[0][n-1];
    end
    if (chain_dropped)
      r.status = ST_DROP;
    else if (chain_dims.size() < 2)
      r.status = ST_EMPTY;
    else
      r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one dimension word; returns at the accepting edge with tvalid still high.
  task automatic send_dim(input logic [DIM_BITS-1:0] d, input logic l);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(d);
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    // word accepted: update the chain copy
    if (chain_dims.size() < STORE_DEPTH) begin
      chain_dims.push_back(d);
      words_kept++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (l) begin
      expected_orders.push_back(best_order());
      chain_dims.delete();
      chain_dropped = 1'b0;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_orders.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DIM_BITS-1:0] pick_dimension(input int style);
    case (style)
      0: return DIM_BITS'($urandom);
      1: return DIM_BITS'($urandom_range(1, 16));
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return DIM_BITS'(1);
          2:       return DIM_MAX - 1'b1;
          default: return DIM_MAX;
        endcase
      end
      default: return ($urandom_range(0, 3) == 0) ? DIM_BITS'($urandom)
                                                   : DIM_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_chain(input int n_dims, input int style);
    for (int i = 0; i < n_dims; i++)
      send_dim(pick_dimension(style), i == n_dims - 1);
  endtask

  // Short fixed chains: single dimension, one matrix, max dims, ties, zeros.
  task automatic test_directed();
    gaps_on = 1'b0;
    send_dim('0, 1'b1);                 // no matrices
    send_dim(DIM_MAX, 1'b1);
    send_dim(DIM_MAX, 1'b0);            // one matrix, zero cost
    send_dim(DIM_MAX, 1'b1);
    for (int i = 0; i < 3; i++)         // largest single product
      send_dim(DIM_MAX, i == 2);
    for (int i = 0; i < 4; i++)         // all splits tie, earliest wins
      send_dim(DIM_BITS'(2), i == 3);
    send_dim(DIM_BITS'(1), 1'b0);       // order matters here
    send_dim(DIM_MAX, 1'b0);
    send_dim(DIM_BITS'(1), 1'b0);
    send_dim(DIM_MAX, 1'b1);
    send_dim('0, 1'b0);                 // zero dimensions
    send_dim(DIM_MAX, 1'b0);
    send_dim('0, 1'b1);
    wait_drained();
  endtask

  // Full store and dropped dimensions.
  task automatic test_capacity();
    gaps_on = 1'b1;
    send_chain(STORE_DEPTH, 0);
    send_chain(STORE_DEPTH, 2);
    send_chain(STORE_DEPTH + 1, 0);
    send_chain(STORE_DEPTH + 4, 3);
    wait_drained();
    // a descending chain puts the best outermost split at the first matrix
    gaps_on = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++)
      send_dim(DIM_BITS'(1000 - 50 * i), i == STORE_DEPTH - 1);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering: block fills and stalls input.
  task automatic test_backpressure();
    hold_asks++;
    gaps_on = 1'b0;
    for (int c = 0; c < 6; c++)
      send_chain($urandom_range(3, 5), 0);
    wait_drained();
  endtask

  task automatic test_random_chains();
    int pick, n_dims, chains;
    chains = 0;
    while (words_kept < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        n_dims = 1;
      else if (pick < 70)
        n_dims = $urandom_range(2, 6);
      else if (pick < 84)
        n_dims = $urandom_range(7, 12);
      else if (pick < 94)
        n_dims = $urandom_range(13, STORE_DEPTH);
      else
        n_dims = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
      gaps_on = ($urandom_range(0, 3) != 0);
      send_chain(n_dims, $urandom_range(0, 3));
      chains++;
      if (chains % 25 == 0) wait_drained();
      if (chains % 120 == 0) hold_asks++;
    end
  endtask

  // Receiver: stall pattern redrawn from always ready, random and sparse, plus requested long holds.
  int       stall_tick = 0;
  int       stall_mode = 0;
  int       hold_left  = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (hold_asks != hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_asks;
    end
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        2:       out_tready <= 1'($urandom_range(0, 1));
        3:       out_tready <= (stall_tick % 8 == 5);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // Result checker
  chain_result_t oldest;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_orders.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'(out_tdata), '0);
      end else begin
        oldest = expected_orders.pop_front();
        if (out_tdata[COST_W-1:0] != oldest.cost)
          report_mismatch("min_cost", 64'(out_tdata[COST_W-1:0]), 64'(oldest.cost));
        if (out_tdata[COST_W +: SPLIT_W] != oldest.split)
          report_mismatch("first_split", 64'(out_tdata[COST_W +: SPLIT_W]), 64'(oldest.split));
        if (out_tdata[COST_W+SPLIT_W +: STAT_W] != oldest.status)
          report_mismatch("status", 64'(out_tdata[COST_W+SPLIT_W +: STAT_W]),
                          64'(oldest.status));
      end
    end
  end

  // Watchdog: cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random_chains();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_orders.size() != 0)
      report_mismatch("results never returned", 64'(expected_orders.size()), '0);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mcm_pkg.sv
hdl/mcm_ram.sv
hdl/mcm_ctrl.sv
hdl/mcm_dp.sv
hdl/matrix_chain_order_dp_top.sv
sim/tb_matrix_chain_order_dp_top.sv
